[hw/rtl/rspt_pkg.sv]
// Shared types and constants for the relay slow PWM timer.
`default_nettype none

package rspt_pkg;

    // Field widths fixed by the command and result formats
    localparam int CMD_W       = 2;
    localparam int MS_W        = 16;
    localparam int RELAY_IDX_W = 3;
    localparam int RELAY_VAL_W = 8;
    localparam int PIN_W       = 8;
    localparam int SETTING_W   = 16;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = SETTING_W;

    localparam logic [MS_W-1:0] MS_PER_SECOND = MS_W'(1000);

    // Command codes; code 3 is unused and leaves state alone
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET_ALL = 2'd1,
        CMD_SET_ONE = 2'd2
    } cmd_t;

    // One command request
    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [MS_W-1:0]        elapsed_ms;
        logic [RELAY_IDX_W-1:0] relay_index;
        logic [RELAY_VAL_W-1:0] relay_value;
    } cmd_req_t;

    // One result
    typedef struct packed {
        logic [PIN_W-1:0] drive_pins;
        logic [PIN_W-1:0] enabled_mask;
    } res_t;

    // Per-channel control from the command decoder
    typedef struct packed {
        logic step;      // command leaves the input register this cycle
        logic second;    // a full second elapsed on this tick
        logic set_on;    // relay enabled by this command
        logic set_off;   // relay disabled by this command
    } chan_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/rspt_channel.sv]
// One relay channel: period/on-time setting, second counter, enable and pin.
`default_nettype none

module rspt_channel (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rspt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  rspt_pkg::chan_ctrl_t         ctrl,
    output logic                         pin_next,
    output logic                         en_next
);
    import rspt_pkg::*;

    logic [SETTING_W-1:0] setting_reg;
    logic [BYTE_W-1:0]    count_reg;
    logic                 pin_reg;
    logic                 en_reg;

    logic [BYTE_W-1:0]    period;
    logic [BYTE_W-1:0]    on_time;
    logic [BYTE_W:0]      count_inc;
    logic [BYTE_W-1:0]    count_wrap;
    logic [BYTE_W-1:0]    count_next;

    assign period  = setting_reg[SETTING_W-1:BYTE_W];
    assign on_time = setting_reg[BYTE_W-1:0];

    // Count one second, wrap at the period (zero period wraps every second)
    assign count_inc  = {1'b0, count_reg} + (BYTE_W+1)'(1);
    assign count_wrap = (count_inc >= {1'b0, period}) ? '0 : count_inc[BYTE_W-1:0];

    // Next channel state for the command in flight
    always_comb
    begin
        count_next = count_reg;
        pin_next   = pin_reg;
        en_next    = en_reg;
        if (ctrl.second)
        begin
            count_next = count_wrap;
            pin_next   = (count_wrap < on_time) && en_reg;
        end
        if (ctrl.set_on)
        begin
            en_next    = 1'b1;
            count_next = '0;
            pin_next   = (on_time != '0);
        end
        if (ctrl.set_off)
        begin
            en_next  = 1'b0;
            pin_next = 1'b0;
        end
    end

    // Setting and channel state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setting_reg <= '0;
            count_reg   <= '0;
            pin_reg     <= 1'b0;
            en_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                setting_reg <= cfg_data;
            end
            if (ctrl.step)
            begin
                count_reg <= count_next;
                pin_reg   <= pin_next;
                en_reg    <= en_next;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/relay_slow_pwm_timer.sv]
// Top level of the relay slow PWM timer.
// Eight (CHANNELS) relay outputs with a PWM in whole seconds. Each command request
// (tick, set all relays, set one relay) gives exactly one result with the pin
// levels and the enable mask after the command. One request is taken every cycle
// while cmd_ready is high; a result passes the input register, the channel
// update and the result register. cmd_ready drops only while both registers
// hold requests and the result is not taken. The user must write settings through
// the cfg port only while no request is in flight; the block does not check it.
`default_nettype none

module relay_slow_pwm_timer #(
    parameter int CHANNELS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rspt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rspt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  rspt_pkg::cmd_req_t                cmd,
    output logic                              res_valid,
    input  logic                              res_ready,
    output rspt_pkg::res_t                    res
);
    import rspt_pkg::*;

    logic             s1_valid_reg;
    cmd_req_t         s1_req_reg;
    logic             res_valid_reg;
    res_t             res_reg;
    logic [MS_W-1:0]  acc_reg;
    logic [MS_W-1:0]  acc_next;
    logic [MS_W-1:0]  ms_sum;
    logic             second_hit;
    logic             is_tick;
    logic             advance;
    logic [PIN_W-1:0] pins_next;
    logic [PIN_W-1:0] en_next;

    // Handshake: the input register drains into the result register
    assign advance   = s1_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Millisecond accumulator, at most one second per tick
    assign is_tick    = (s1_req_reg.command == CMD_TICK);
    assign ms_sum     = acc_reg + s1_req_reg.elapsed_ms;
    assign second_hit = (ms_sum >= MS_PER_SECOND);
    assign acc_next   = second_hit ? (ms_sum - MS_PER_SECOND) : ms_sum;

    // Channels
    for (genvar i = 0; i < PIN_W; i++)
    begin : g_chan
        if (i < CHANNELS)
        begin : g_used
            chan_ctrl_t ctrl;
            logic       sel;
            logic       turn_on;

            // Decode what this command does to this channel
            always_comb
            begin
                sel     = 1'b0;
                turn_on = 1'b0;
                case (s1_req_reg.command)
                    CMD_SET_ALL:
                    begin
                        sel     = 1'b1;
                        turn_on = s1_req_reg.relay_value[i];
                    end
                    CMD_SET_ONE:
                    begin
                        sel     = (s1_req_reg.relay_index == RELAY_IDX_W'(i));
                        turn_on = (s1_req_reg.relay_value != '0);
                    end
                    default:
                    begin
                        sel     = 1'b0;
                        turn_on = 1'b0;
                    end
                endcase
                ctrl.step    = advance;
                ctrl.second  = is_tick && second_hit;
                ctrl.set_on  = sel && turn_on;
                ctrl.set_off = sel && !turn_on;
            end

            rspt_channel u_channel (
                .clk      (clk),
                .rst_n    (rst_n),
                .cfg_we   (cfg_valid && (cfg_index == CFG_INDEX_W'(i))),
                .cfg_data (cfg_data),
                .ctrl     (ctrl),
                .pin_next (pins_next[i]),
                .en_next  (en_next[i])
            );
        end
        else
        begin : g_unused
            assign pins_next[i] = 1'b0;
            assign en_next[i]   = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (cmd_ready)
            begin
                s1_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (advance && is_tick)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            s1_req_reg <= cmd;
        end
        if (advance)
        begin
            res_reg.drive_pins   <= pins_next;
            res_reg.enabled_mask <= en_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rspt_checker.sv]
// Port-level checks for the relay slow PWM timer, bound to the top level.
`default_nettype none

module rspt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input logic               res_valid,
    input logic               res_ready,
    input rspt_pkg::res_t     res
);
    import rspt_pkg::*;

    logic [1:0] inflight_reg;

    // Requests accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 2'((cmd_valid && cmd_ready) ? 1 : 0)
                            - 2'((res_valid && res_ready) ? 1 : 0);
        end
    end

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("result changed while stalled");

    // A driven pin always belongs to an enabled relay
    a_pin_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.drive_pins & ~res.enabled_mask) == '0))
        else $error("pin driven on a disabled relay");

    // No result without a request behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (inflight_reg != 2'd0))
        else $error("result without request");

    // At most two requests in flight
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("too many requests in flight");

    // An empty block takes a request
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == 2'd0) |-> cmd_ready)
        else $error("empty block not ready");

endmodule

bind relay_slow_pwm_timer rspt_checker u_rspt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

`default_nettype wire
